>>> rtl/wildcard_word_filter_min_macros.svh
// Assertion helpers used by the filter RTL
`ifndef WILDCARD_WORD_FILTER_MIN_MACROS_SVH
`define WILDCARD_WORD_FILTER_MIN_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define WWFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WWFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/wwfm_pkg.sv
package wwfm_pkg;

	localparam int unsigned NUM_REGS = 5;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_0   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_3   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN = 3'd4;

	localparam logic [1:0] CMD_WORD  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	localparam logic [5:0] MAX_LEN   = 6'd32;
	localparam logic [7:0] WILDCARD  = 8'd95;
	localparam int unsigned BANK_DEPTH = 32;
	localparam int unsigned STORE_DEPTH = 2 * BANK_DEPTH;
	localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);

endpackage

>>> rtl/wwfm_src_if.sv
interface wwfm_src_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] ch;
	logic       last;
	logic [4:0] position;

	modport source (output valid, cmd, ch, last, position, input ready);
	modport sink (input valid, cmd, ch, last, position, output ready);
endinterface

>>> rtl/wwfm_res_if.sv
interface wwfm_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        is_match;
	logic        new_best;
	logic [15:0] match_count;
	logic [7:0]  best_char;
	logic [5:0]  best_length;

	modport source (output valid, kind, is_match, new_best, match_count, best_char,
		best_length, input ready);
	modport sink (input valid, kind, is_match, new_best, match_count, best_char,
		best_length, output ready);
endinterface

>>> rtl/wwfm_cfg_if.sv
interface wwfm_cfg_if
	import wwfm_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [63:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wwfm_ram.sv
module wwfm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/wildcard_word_filter_min.sv
// Wildcard word filter.
// src_ch carries commands: word bytes (last marks a word's final byte), reads of
// one byte of the best match, and clears. cfg writes the pattern bytes and the
// pattern length; write it only while the block is idle. cfg is always ready.
// res_ch returns one word per finished word (verdict, new-best flag, match count,
// best length) and one word per read command (requested byte of the best match).
// Word bytes that are not last, clears and unused commands return nothing.
// One command enters per cycle while src_ch is ready. A result passes through
// stage 1, loaded with the store read when its command is accepted, and then
// the output register, which loads when stage 1 moves on.
// Current and best word live in the two banks of a 64-byte store; the state
// update after each store read is forwarded to the next command's address.
// When res_ch stalls, one command can sit behind the output register; src_ch
// ready drops only while that command also has a result to deliver.
// Reset clears count, best length and the word in progress; the store keeps its
// contents and needs no clearing pass.
module wildcard_word_filter_min
	import wwfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wwfm_src_if.sink   src_ch,
	wwfm_res_if.source res_ch,
	wwfm_cfg_if.sink   cfg
);

	`include "wildcard_word_filter_min_macros.svh"

	typedef enum logic [1:0] {ORD_UNDECIDED, ORD_LESS, ORD_GREATER} order_t;

	logic [63:0] pattern_q [4];
	logic [5:0]  pattern_len_q;

	logic        s1_valid;
	logic [1:0]  cmd_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	logic [4:0]  position_s1;

	logic        best_sel_q, best_sel_n;
	logic [5:0]  best_len_q, best_len_n;
	logic [5:0]  cur_len_q, cur_len_n;
	logic        matching_q, matching_n;
	order_t      order_q, order_n;
	logic        too_long_q, too_long_n;
	logic [15:0] count_q, count_n;

	logic        out_valid_q;
	logic        kind_q, is_match_q, new_best_q;
	logic [15:0] count_out_q;
	logic [7:0]  char_q;
	logic [5:0]  best_len_out_q;

	logic        has_result, s1_go, accept;
	logic        is_match, new_best, less, rd_kind;
	logic [7:0]  rd_char, pbyte, rdata;
	logic        ram_we, ram_re;
	logic [STORE_AW-1:0] ram_waddr, ram_raddr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pattern_q[i] <= '0;
			end
			pattern_len_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index <= REG_PATTERN_3) begin
				pattern_q[cfg.index[1:0]] <= cfg.data;
			end else if (cfg.index == REG_PATTERN_LEN) begin
				pattern_len_q <= cfg.data[5:0];
			end
		end
	end

	assign has_result = (cmd_s1 == CMD_WORD && last_s1) || cmd_s1 == CMD_READ;
	assign s1_go = s1_valid && (!has_result || !out_valid_q || res_ch.ready);
	assign src_ch.ready = !s1_valid || s1_go;
	assign accept = src_ch.valid && src_ch.ready;

	assign pbyte = pattern_q[cur_len_q[4:3]][cur_len_q[2:0]*8 +: 8];

	always_comb begin
		best_sel_n = best_sel_q;
		best_len_n = best_len_q;
		cur_len_n  = cur_len_q;
		matching_n = matching_q;
		order_n    = order_q;
		too_long_n = too_long_q;
		count_n    = count_q;
		is_match   = 1'b0;
		new_best   = 1'b0;
		less       = 1'b0;
		rd_kind    = KIND_VERDICT;
		rd_char    = '0;
		if (s1_valid) begin
			case (cmd_s1)
				CMD_WORD: begin
					if (cur_len_q < MAX_LEN) begin
						if (pbyte != WILDCARD && pbyte != ch_s1) begin
							matching_n = 1'b0;
						end
						if (order_q == ORD_UNDECIDED) begin
							if (cur_len_q >= best_len_q) begin
								order_n = ORD_GREATER;
							end else if (ch_s1 < rdata) begin
								order_n = ORD_LESS;
							end else if (ch_s1 > rdata) begin
								order_n = ORD_GREATER;
							end
						end
						cur_len_n = cur_len_q + 6'd1;
					end else begin
						too_long_n = 1'b1;
					end
					if (last_s1) begin
						is_match = !too_long_n && matching_n && pattern_len_q != '0
							&& cur_len_n == pattern_len_q;
						less = order_n == ORD_LESS
							|| (order_n == ORD_UNDECIDED && cur_len_n < best_len_q);
						if (is_match) begin
							if (count_q != '1) begin
								count_n = count_q + 16'd1;
							end
							if (best_len_q == '0 || less) begin
								new_best   = 1'b1;
								best_sel_n = ~best_sel_q;
								best_len_n = cur_len_n;
							end
						end
						cur_len_n  = '0;
						matching_n = 1'b1;
						order_n    = ORD_UNDECIDED;
						too_long_n = 1'b0;
					end
				end
				CMD_READ: begin
					rd_kind = KIND_READOUT;
					if ({1'b0, position_s1} < best_len_q) begin
						rd_char = rdata;
					end
				end
				CMD_CLEAR: begin
					count_n    = '0;
					best_len_n = '0;
					cur_len_n  = '0;
					matching_n = 1'b1;
					order_n    = ORD_UNDECIDED;
					too_long_n = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// addresses use the state after the command in s1 (forwarded)
	assign ram_re = accept && (src_ch.cmd == CMD_WORD || src_ch.cmd == CMD_READ);
	assign ram_raddr = {best_sel_n,
		(src_ch.cmd == CMD_READ) ? src_ch.position : cur_len_n[4:0]};
	assign ram_we = accept && src_ch.cmd == CMD_WORD && cur_len_n < MAX_LEN;
	assign ram_waddr = {~best_sel_n, cur_len_n[4:0]};

	wwfm_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(src_ch.ch),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			best_sel_q <= 1'b0;
			best_len_q <= '0;
			cur_len_q  <= '0;
			matching_q <= 1'b1;
			order_q    <= ORD_UNDECIDED;
			too_long_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (src_ch.ready) begin
				s1_valid <= src_ch.valid;
			end
			if (s1_go) begin
				best_sel_q <= best_sel_n;
				best_len_q <= best_len_n;
				cur_len_q  <= cur_len_n;
				matching_q <= matching_n;
				order_q    <= order_n;
				too_long_q <= too_long_n;
				count_q    <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= src_ch.cmd;
			ch_s1       <= src_ch.ch;
			last_s1     <= src_ch.last;
			position_s1 <= src_ch.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			kind_q         <= rd_kind;
			is_match_q     <= is_match;
			new_best_q     <= new_best;
			count_out_q    <= count_n;
			char_q         <= rd_char;
			best_len_out_q <= best_len_n;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.kind        = kind_q;
	assign res_ch.is_match    = is_match_q;
	assign res_ch.new_best    = new_best_q;
	assign res_ch.match_count = count_out_q;
	assign res_ch.best_char   = char_q;
	assign res_ch.best_length = best_len_out_q;

	`WWFM_ASSERT_NOW(a_best_len_range, 1'b1, best_len_q <= MAX_LEN,
		"best length beyond MAX_LEN")
	`WWFM_ASSERT_NOW(a_new_best_is_match, out_valid_q && new_best_q, is_match_q,
		"new best reported on a word that does not match")
	`WWFM_ASSERT_NOW(a_no_accept_on_stall, accept, !s1_valid || s1_go,
		"command accepted while stage 1 is stalled")
	`WWFM_ASSERT_NEXT(a_clear_resets, s1_go && cmd_s1 == CMD_CLEAR,
		count_q == '0 && best_len_q == '0 && cur_len_q == '0,
		"clear did not reset count and best")

endmodule

>>> tb/sv/tb_wildcard_word_filter_min.sv
module tb_wildcard_word_filter_min;
	import wwfm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum logic [1:0] {ORDER_OPEN, ORDER_BELOW, ORDER_ABOVE} rank_t;

	typedef struct packed {
		logic        kind;
		logic        is_match;
		logic        new_best;
		logic [15:0] match_count;
		logic [7:0]  best_char;
		logic [5:0]  best_length;
	} filter_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	wwfm_src_if src_ch();
	wwfm_res_if res_ch();
	wwfm_cfg_if cfg();

	wildcard_word_filter_min dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src_ch (src_ch),
		.res_ch (res_ch),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// filter state as the block should hold it
	logic [63:0] pat_words [4] = '{default: 64'h0};
	logic [5:0]  pat_len = '0;
	logic [7:0]  word_mem [64] = '{default: 8'h00};
	logic        bank_sel = 1'b0;
	logic [5:0]  best_len = '0;
	logic [5:0]  cur_len = '0;
	logic        matching = 1'b1;
	rank_t       rank = ORDER_OPEN;
	logic        overflow = 1'b0;
	logic [15:0] hits = '0;

	filter_reply_t owed_replies [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int src_gap_max = 0;
	int sink_gap_max = 0;
	logic sink_hold;

	function automatic void restart_word();
		cur_len = '0;
		matching = 1'b1;
		rank = ORDER_OPEN;
		overflow = 1'b0;
	endfunction

	function automatic void apply_filter_cmd(logic [1:0] cmd, logic [7:0] ch, logic last,
		logic [4:0] pos);
		filter_reply_t r;
		logic [4:0] idx;
		logic [7:0] pat;
		int best_base;
		int cur_base;
		logic hit;
		logic below;
		logic promote;
		best_base = bank_sel ? 32 : 0;
		cur_base = bank_sel ? 0 : 32;
		r = '0;
		case (cmd)
			CMD_WORD: begin
				if (cur_len < MAX_LEN) begin
					idx = cur_len[4:0];
					pat = pat_words[idx[4:3]][idx[2:0]*8 +: 8];
					if (pat != WILDCARD && pat != ch)
						matching = 1'b0;
					word_mem[cur_base + idx] = ch;
					if (rank == ORDER_OPEN) begin
						if (idx >= best_len)
							rank = ORDER_ABOVE;
						else if (ch < word_mem[best_base + idx])
							rank = ORDER_BELOW;
						else if (ch > word_mem[best_base + idx])
							rank = ORDER_ABOVE;
					end
					cur_len++;
				end else begin
					overflow = 1'b1;
				end
				if (last) begin
					hit = !overflow && matching && pat_len != 0 && cur_len == pat_len;
					below = rank == ORDER_BELOW || (rank == ORDER_OPEN && cur_len < best_len);
					promote = hit && (best_len == 0 || below);
					if (hit && hits != 16'hffff)
						hits++;
					if (promote) begin
						bank_sel = ~bank_sel;
						best_len = cur_len;
					end
					r.kind = KIND_VERDICT;
					r.is_match = hit;
					r.new_best = promote;
					r.match_count = hits;
					r.best_length = best_len;
					owed_replies.push_back(r);
					restart_word();
				end
			end
			CMD_READ: begin
				r.kind = KIND_READOUT;
				r.match_count = hits;
				r.best_length = best_len;
				if (pos < best_len)
					r.best_char = word_mem[best_base + pos];
				owed_replies.push_back(r);
			end
			CMD_CLEAR: begin
				hits = '0;
				best_len = '0;
				restart_word();
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(string what, longint unsigned got, longint unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : check_replies
		filter_reply_t got;
		filter_reply_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind = res_ch.kind;
			got.is_match = res_ch.is_match;
			got.new_best = res_ch.new_best;
			got.match_count = res_ch.match_count;
			got.best_char = res_ch.best_char;
			got.best_length = res_ch.best_length;
			if (owed_replies.size() == 0) begin
				report_mismatch("word with none owed", got, 0);
			end else begin
				want = owed_replies.pop_front();
				check_field("kind", got.kind, want.kind);
				check_field("is_match", got.is_match, want.is_match);
				check_field("new_best", got.new_best, want.new_best);
				check_field("match_count", got.match_count, want.match_count);
				check_field("best_char", got.best_char, want.best_char);
				check_field("best_length", got.best_length, want.best_length);
			end
		end
	end

	// result side: random stall after each word, forced low while held
	always @(posedge clk) begin : drive_ready
		int sink_wait;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_wait = 0;
		end else if (sink_hold) begin
			res_ch.ready <= 1'b0;
		end else if (res_ch.valid && res_ch.ready) begin
			sink_wait = $urandom_range(0, sink_gap_max);
			res_ch.ready <= (sink_wait == 0);
		end else if (sink_wait > 0) begin
			sink_wait--;
			res_ch.ready <= (sink_wait == 0);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wildcard_word_filter_min regression: fail");
			$finish;
		end
	end

	task automatic send_cmd(logic [1:0] cmd, logic [7:0] ch, logic last, logic [4:0] pos);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.cmd <= cmd;
		src_ch.ch <= ch;
		src_ch.last <= last;
		src_ch.position <= pos;
		do @(posedge clk); while (!src_ch.ready);
		apply_filter_cmd(cmd, ch, last, pos);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_cmd(CMD_WORD, s[i], i == s.len() - 1, 5'($urandom));
	endtask

	// optionally slips reads, unused commands and clears in between bytes
	task automatic send_word(logic [7:0] w [$], bit interleave);
		int pick;
		for (int i = 0; i < w.size(); i++) begin
			if (interleave && $urandom_range(0, 15) == 0) begin
				pick = $urandom_range(0, 5);
				if (pick < 3)
					send_cmd(CMD_READ, 8'($urandom), 1'($urandom), 5'($urandom));
				else if (pick < 5)
					send_cmd(CMD_UNUSED, 8'($urandom), 1'($urandom), 5'($urandom));
				else
					send_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom));
			end
			send_cmd(CMD_WORD, w[i], i == w.size() - 1, 5'($urandom));
		end
	endtask

	task automatic drain();
		src_ch.valid <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_PATTERN_LEN)
			pat_len = data[5:0];
		else
			pat_words[idx[1:0]] = data;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// bytes past the string get random contents
	task automatic load_pattern(string s, logic [5:0] len);
		logic [63:0] regs [4];
		for (int i = 0; i < 4; i++)
			regs[i] = {$urandom, $urandom};
		for (int i = 0; i < s.len() && i < 32; i++)
			regs[i/8][(i%8)*8 +: 8] = s[i];
		drain();
		for (int i = 0; i < 4; i++)
			write_reg(REG_PATTERN_0 + REG_IDX_W'(i), regs[i]);
		write_reg(REG_PATTERN_LEN, {58'd0, len});
	endtask

	task automatic test_reset_state();
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd0);
		send_cmd(CMD_READ, 8'hff, 1'b1, 5'd31);
		send_text("a");
		send_cmd(CMD_UNUSED, 8'h5a, 1'b1, 5'd7);
	endtask

	task automatic test_directed_words();
		load_pattern("c_t", 6'd3);
		send_text("cat");
		send_text("cut");
		send_text("cat");
		send_cmd(CMD_WORD, "c", 1'b0, 5'd0);
		send_cmd(CMD_WORD, 8'h00, 1'b0, 5'd0);
		send_cmd(CMD_WORD, "t", 1'b1, 5'd0);
		send_cmd(CMD_WORD, "c", 1'b0, 5'd31);
		send_cmd(CMD_WORD, 8'hff, 1'b0, 5'd31);
		send_cmd(CMD_WORD, "t", 1'b1, 5'd31);
		send_text("cab");
		send_text("ca");
		for (int p = 0; p < 4; p++)
			send_cmd(CMD_READ, 8'h00, 1'b0, 5'(p));
		send_cmd(CMD_UNUSED, 8'hff, 1'b1, 5'd31);
		// clear in the middle of a word restarts it
		send_cmd(CMD_WORD, "c", 1'b0, 5'd0);
		send_cmd(CMD_WORD, "a", 1'b0, 5'd0);
		send_cmd(CMD_CLEAR, 8'h00, 1'b0, 5'd0);
		send_text("t");
		send_text("cot");
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd1);
	endtask

	task automatic test_order_prefix();
		load_pattern("ab___", 6'd5);
		send_text("abxyz");
		// best is now a longer word sharing this prefix
		load_pattern("ab_", 6'd3);
		send_text("abx");
		load_pattern("ab___", 6'd5);
		send_text("abxaa");
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd2);
	endtask

	task automatic test_length_limits();
		string wild;
		logic [7:0] w32 [$];
		logic [7:0] w33 [$];
		wild = "";
		repeat (32) wild = {wild, "_"};
		send_cmd(CMD_CLEAR, 8'h00, 1'b0, 5'd0);
		load_pattern(wild, MAX_LEN);
		w32.push_back(8'h00);
		w32.push_back(8'hff);
		repeat (30) w32.push_back(8'($urandom));
		send_word(w32, 1'b0);
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd0);
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd1);
		send_cmd(CMD_READ, 8'h00, 1'b0, 5'd31);
		w33 = w32;
		w33.push_back(8'($urandom));
		send_word(w33, 1'b0);
		load_pattern(wild, 6'd63);
		send_word(w32, 1'b0);
	endtask

	task automatic test_backpressure();
		load_pattern("ab", 6'd2);
		src_gap_max = 0;
		sink_gap_max = 0;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (60) @(posedge clk);
				sink_hold <= 1'b0;
			end
			repeat (12) begin
				send_text("ab");
				send_cmd(CMD_READ, 8'($urandom), 1'($urandom), 5'($urandom));
			end
		join
	endtask

	task automatic test_random_dictionary();
		string ab;
		string pat;
		logic [7:0] w [$];
		logic [7:0] c;
		int mode;
		int pick;
		int plen;
		int span;
		int budget;
		int done;
		int total;
		ab = "abc";
		total = 0;
		while (total < 1300) begin
			mode = $urandom_range(0, 3);
			src_gap_max = (mode == 0 || mode == 2) ? 0 : 10;
			sink_gap_max = (mode == 0 || mode == 1) ? 0 : 10;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				plen = 0;
			else if (pick == 1)
				plen = 32;
			else if (pick == 2)
				plen = $urandom_range(33, 63);
			else if (pick < 5)
				plen = $urandom_range(9, 31);
			else
				plen = $urandom_range(1, 8);
			span = (plen == 0) ? 0 : (plen > 32 ? 32 : plen);
			pat = "";
			for (int i = 0; i < span; i++) begin
				if ($urandom_range(0, 2) == 0)
					pat = {pat, "_"};
				else
					pat = {pat, ab.substr(i % 3, i % 3)};
			end
			for (int i = 0; i < span; i++)
				if (pat[i] != WILDCARD && $urandom_range(0, 1) == 0)
					pat.putc(i, ab[$urandom_range(0, 2)]);
			load_pattern(pat, 6'(plen));
			budget = $urandom_range(60, 160);
			done = 0;
			while (done < budget) begin
				pick = $urandom_range(0, 99);
				w.delete();
				if (pick < 8) begin
					send_cmd(CMD_READ, 8'($urandom), 1'($urandom), 5'($urandom));
					done++;
				end else if (pick < 10) begin
					send_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom));
					done++;
				end else if (pick < 12) begin
					send_cmd(CMD_UNUSED, 8'($urandom), 1'($urandom), 5'($urandom));
				end else if (pick < 80) begin
					for (int i = 0; i < (span == 0 ? $urandom_range(1, 6) : span); i++) begin
						c = (i < span) ? pat[i] : WILDCARD;
						if (c == WILDCARD)
							c = ab[$urandom_range(0, 2)];
						w.push_back(c);
					end
					if ($urandom_range(0, 6) == 0)
						w[$urandom_range(0, w.size() - 1)] = 8'($urandom);
					send_word(w, 1'b0);
					done += w.size();
				end else begin
					if ($urandom_range(0, 9) == 0)
						repeat ($urandom_range(33, 40)) w.push_back(8'($urandom));
					else
						repeat ($urandom_range(1, 10)) w.push_back(8'($urandom));
					send_word(w, 1'b1);
					done += w.size();
				end
			end
			total += done;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sink_hold = 1'b0;
		src_ch.valid = 1'b0;
		src_ch.cmd = CMD_WORD;
		src_ch.ch = '0;
		src_ch.last = 1'b0;
		src_ch.position = '0;
		res_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_PATTERN_0;
		cfg.data = '0;
		restart_word();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_max = 3;
		sink_gap_max = 3;
		test_reset_state();
		test_directed_words();
		test_order_prefix();
		test_length_limits();
		test_backpressure();
		test_random_dictionary();

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("wildcard_word_filter_min regression: pass");
		else
			$display("wildcard_word_filter_min regression: fail");
		$finish;
	end

endmodule
